// ===== design/rms_pkg.sv =====
package rms_pkg;

   // Default sizes handed to the top level parameters.
   localparam int DEF_MAX_TASK_SLOTS = 8;
   localparam int DEF_COUNT_BITS     = 16;

   // Fixed field widths of the stream payloads.
   localparam int SLOT_W     = 3;
   localparam int PERIOD_W   = 16;
   localparam int BURST_W    = 16;
   localparam int ACTIVE_W   = 4;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 8;

   // Request kinds carried on tuser.
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   // Control from the sequencer to the shared compare unit.
   typedef struct packed {
      logic start;   // clear the best candidate at the start of a tick
      logic step;    // one task entry is on the read data this cycle
   } scan_ctl_type;

endpackage

// ===== design/rms_ram.sv =====
module rms_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== design/rms_slot_unit.sv =====
module rms_slot_unit #(
   parameter int SLOT_BITS  = 3,
   parameter int COUNT_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  rms_pkg::scan_ctl_type     ctl,
   input  logic [SLOT_BITS-1:0]      idx,
   input  logic [COUNT_BITS-1:0]     period,
   input  logic [COUNT_BITS-1:0]     burst,
   input  logic [COUNT_BITS-1:0]     rem,
   input  logic [COUNT_BITS-1:0]     phase,
   output logic [COUNT_BITS-1:0]     rem_new,
   output logic [COUNT_BITS-1:0]     phase_new,
   output logic                      found,
   output logic [SLOT_BITS-1:0]      pick,
   output logic [COUNT_BITS-1:0]     best_rem,
   output logic [COUNT_BITS-1:0]     best_phase
);

   import rms_pkg::*;

   logic [COUNT_BITS-1:0] phase_inc;
   logic                  take;
   logic                  found_ff;
   logic                  found_in;
   logic [SLOT_BITS-1:0]  pick_ff;
   logic [COUNT_BITS-1:0] best_period_ff;
   logic [COUNT_BITS-1:0] best_rem_ff;
   logic [COUNT_BITS-1:0] best_phase_ff;

   // Release the task when its phase is zero, then advance the phase.
   always_comb begin
      rem_new   = (phase == '0) ? burst : rem;
      phase_inc = phase + COUNT_BITS'(1);
      phase_new = (phase_inc >= period) ? '0 : phase_inc;
   end

   // A ready task wins only on a strictly shorter period, so ties keep the lower index.
   assign take = (rem_new != '0) && (!found_ff || (period < best_period_ff));

   always_comb begin
      found_in = found_ff;
      if (ctl.start) begin
         found_in = 1'b0;
      end else if (ctl.step && take) begin
         found_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   // Best candidate payload, with the values it will be written back with.
   always_ff @(posedge clock) begin
      if (ctl.step && take && !ctl.start) begin
         pick_ff        <= idx;
         best_period_ff <= period;
         best_rem_ff    <= rem_new;
         best_phase_ff  <= phase_new;
      end
   end

   assign found      = found_ff;
   assign pick       = pick_ff;
   assign best_rem   = best_rem_ff;
   assign best_phase = best_phase_ff;

endmodule

// ===== design/rate_monotonic_scheduler.sv =====
// Rate-monotonic tick scheduler.
// Requests arrive on the req_ stream. tuser selects the kind: a load transfer
// writes one task entry (period, burst) and clears its remaining work and
// phase; a tick transfer advances the schedule by one time step and returns
// exactly one transfer on the rsp_ stream with the task that ran, an idle
// flag and a switch flag. Loads return nothing. The csr_ channel writes the
// number of active task entries; write it only while no tick is in flight.
// A load is written in the cycle it is accepted. A tick walks the active
// entries one per cycle through a single shared release and compare unit
// over the shared read address of the parameter and state memories, and the
// block accepts no request meanwhile. The result sits in an output register;
// a new request is accepted while it waits. If the receiver stalls, the next
// tick halts at its final write-back until the previous result is taken.
// Reset clears the active count, all remaining work and phases and marks the
// previous tick as idle; loaded periods and bursts are undefined until
// written.
module rate_monotonic_scheduler #(
   parameter int MAX_TASK_SLOTS = rms_pkg::DEF_MAX_TASK_SLOTS,
   parameter int COUNT_BITS     = rms_pkg::DEF_COUNT_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request stream.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata: task_slot[2:0], task_period[18:3], task_burst[34:19], zeros above.
   input  logic [rms_pkg::REQ_DATA_W-1:0]    req_tdata,
   // tuser: func (0 load, 1 tick).
   input  logic                              req_tuser,
   // Result stream.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata: running_task[2:0], cpu_idle[3], switched[4], zeros above.
   output logic [rms_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // Active task count register.
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rms_pkg::ACTIVE_W-1:0]      csr_data
);

   import rms_pkg::*;

   localparam int SLOT_BITS = (MAX_TASK_SLOTS > 1) ? $clog2(MAX_TASK_SLOTS) : 1;
   localparam int CNT_BITS  = $clog2(MAX_TASK_SLOTS + 1);
   localparam int ENTRY_W   = 2 * COUNT_BITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   state_type               state_ff;
   logic [ACTIVE_W-1:0]     active_ff;
   logic [SLOT_BITS-1:0]    idx_ff;
   logic                    prev_idle_ff;
   logic [SLOT_BITS-1:0]    prev_idx_ff;
   logic                    rsp_valid_ff;
   logic [RSP_DATA_W-1:0]   rsp_data_ff;
   logic [MAX_TASK_SLOTS-1:0] valid_ff;
   logic                    rd_valid_ff;

   logic                    req_go;
   logic                    load_go;
   logic                    tick_go;
   logic                    commit_go;
   logic                    scan_last;
   logic [CNT_BITS-1:0]     n_tasks;

   logic [SLOT_W-1:0]       req_slot;
   logic [PERIOD_W-1:0]     req_period;
   logic [BURST_W-1:0]      req_burst;
   logic                    slot_ok;

   logic                    wr_en;
   logic [SLOT_BITS-1:0]    wr_addr;
   logic [ENTRY_W-1:0]      par_wr_data;
   logic [ENTRY_W-1:0]      st_wr_data;
   logic [SLOT_BITS-1:0]    rd_addr;
   logic [ENTRY_W-1:0]      par_rd_data;
   logic [ENTRY_W-1:0]      st_rd_data;

   logic [COUNT_BITS-1:0]   rem_rd;
   logic [COUNT_BITS-1:0]   phase_rd;
   logic [COUNT_BITS-1:0]   rem_new;
   logic [COUNT_BITS-1:0]   phase_new;
   logic                    found;
   logic [SLOT_BITS-1:0]    pick;
   logic [COUNT_BITS-1:0]   best_rem;
   logic [COUNT_BITS-1:0]   best_phase;
   logic                    switched;
   scan_ctl_type            scan_ctl;

   // Request field unpacking.
   assign req_slot   = req_tdata[SLOT_W-1:0];
   assign req_period = req_tdata[SLOT_W +: PERIOD_W];
   assign req_burst  = req_tdata[SLOT_W+PERIOD_W +: BURST_W];
   assign slot_ok    = (32'(req_slot) < 32'(MAX_TASK_SLOTS));

   assign req_tready = (state_ff == ST_IDLE);
   assign req_go     = req_tvalid && req_tready;
   assign load_go    = req_go && (req_tuser == FUNC_LOAD) && slot_ok;
   assign tick_go    = req_go && (req_tuser == FUNC_TICK);
   assign commit_go  = (state_ff == ST_COMMIT) && (!rsp_valid_ff || rsp_tready);

   // Active count saturates at the number of task slots.
   assign n_tasks   = (32'(active_ff) > 32'(MAX_TASK_SLOTS)) ? CNT_BITS'(MAX_TASK_SLOTS)
                                                              : CNT_BITS'(active_ff);
   assign scan_last = ((32'(idx_ff) + 32'd1) == 32'(n_tasks));

   // Memory write port: load, scan write-back, or the final decrement.
   always_comb begin
      wr_en       = 1'b0;
      wr_addr     = idx_ff;
      par_wr_data = {COUNT_BITS'(req_burst), COUNT_BITS'(req_period)};
      st_wr_data  = {rem_new, phase_new};
      case (state_ff)
         ST_IDLE: begin
            wr_en   = load_go;
            wr_addr = SLOT_BITS'(req_slot);
            st_wr_data = '0;
         end
         ST_SCAN: begin
            wr_en = 1'b1;
         end
         ST_COMMIT: begin
            wr_en      = commit_go && found;
            wr_addr    = pick;
            st_wr_data = {best_rem - COUNT_BITS'(1), best_phase};
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // The scan reads one entry ahead of the one being processed.
   assign rd_addr = (state_ff == ST_SCAN) ? (idx_ff + SLOT_BITS'(1)) : '0;

   rms_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_TASK_SLOTS)
   ) u_param_ram (
      .clock   (clock),
      .wr_en   (wr_en && (state_ff == ST_IDLE)),
      .wr_addr (wr_addr),
      .wr_data (par_wr_data),
      .rd_addr (rd_addr),
      .rd_data (par_rd_data)
   );

   rms_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_TASK_SLOTS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (st_wr_data),
      .rd_addr (rd_addr),
      .rd_data (st_rd_data)
   );

   // Entries never written since reset read as zero work and zero phase.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rem_rd   = rd_valid_ff ? st_rd_data[ENTRY_W-1:COUNT_BITS] : '0;
   assign phase_rd = rd_valid_ff ? st_rd_data[COUNT_BITS-1:0]       : '0;

   assign scan_ctl.start = tick_go;
   assign scan_ctl.step  = (state_ff == ST_SCAN);

   rms_slot_unit #(
      .SLOT_BITS  (SLOT_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_slot_unit (
      .clock      (clock),
      .reset      (reset),
      .ctl        (scan_ctl),
      .idx        (idx_ff),
      .period     (par_rd_data[COUNT_BITS-1:0]),
      .burst      (par_rd_data[ENTRY_W-1:COUNT_BITS]),
      .rem        (rem_rd),
      .phase      (phase_rd),
      .rem_new    (rem_new),
      .phase_new  (phase_new),
      .found      (found),
      .pick       (pick),
      .best_rem   (best_rem),
      .best_phase (best_phase)
   );

   assign switched = found ? (prev_idle_ff || (prev_idx_ff != pick)) : !prev_idle_ff;

   // Sequencer, previous choice and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= '0;
         idx_ff       <= '0;
         prev_idle_ff <= 1'b1;
         prev_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            active_ff <= csr_data;
         end
         if (rsp_tready && !commit_go) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               idx_ff <= '0;
               if (tick_go) begin
                  state_ff <= (n_tasks == '0) ? ST_COMMIT : ST_SCAN;
               end
            end
            ST_SCAN: begin
               idx_ff <= idx_ff + SLOT_BITS'(1);
               if (scan_last) begin
                  state_ff <= ST_COMMIT;
               end
            end
            ST_COMMIT: begin
               if (commit_go) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {3'b000, switched, !found,
                                   found ? SLOT_W'(pick) : SLOT_W'(0)};
                  prev_idle_ff <= !found;
                  prev_idx_ff  <= found ? pick : '0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   // An idle result never names a task.
   a_idle_zero_task: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tdata[3] || (rsp_tdata[2:0] == 3'd0)))
      else $error("idle result carries a task index");

   // A load never produces a result.
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == FUNC_LOAD) && !rsp_tvalid)
      |=> !rsp_tvalid)
      else $error("load transfer produced a result");

   // The best candidate never lies ahead of the entry being scanned.
   a_pick_behind: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && found) |-> (pick < idx_ff))
      else $error("picked task is beyond the scan position");

   // A new result is only loaded once the previous one has been taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> ($stable(rsp_tdata) || !$past(commit_go)))
      else $error("pending result was overwritten");

endmodule
